// ===== sv/median_filter_3x3_defines.svh =====
// Assertion macros shared by the median filter modules.
// No dependencies; included by each module that carries assertions.
`ifndef MEDIAN_FILTER_3X3_DEFINES_SVH
`define MEDIAN_FILTER_3X3_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MF3_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MF3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mf3_pkg.sv =====
// Shared types and constants for the 3x3 median filter.
// No dependencies; used by every module of the block except mf3_ram.
package mf3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int PIX_W      = 8;
    localparam int DIM_W      = 11;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int MIN_DIM    = 3;
    localparam int WIN_N      = 9;

    // Queue between front and back; depth must be a power of two.
    localparam int QDEPTH = 4;
    localparam int QA_W   = $clog2(QDEPTH);
    localparam int LVL_W  = $clog2(QDEPTH + 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DIM_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } t_cfg_reg;

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [WIN_N-1:0][PIX_W-1:0] t_win;

    // One window on its way from the front to the back.
    typedef struct packed {
        t_win win;
        logic line_end;
        logic frame_end;
    } t_item;

endpackage

// ===== sv/mf3_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mf3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/mf3_front.sv =====
// Front end: geometry registers, raster counters, line stores and window.
// Depends on mf3_pkg, mf3_ram and the assertion macro header.
`include "median_filter_3x3_defines.svh"

module mf3_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [mf3_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [mf3_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_valid,
    input  mf3_pkg::t_pix                  i_pixel,
    output logic                           o_stall,
    input  logic [mf3_pkg::LVL_W-1:0]      i_q_level,
    output logic                           o_push,
    output mf3_pkg::t_item                 o_item
);

    logic [mf3_pkg::DIM_W-1:0] r_width;
    logic [mf3_pkg::DIM_W-1:0] r_height;
    logic [mf3_pkg::DIM_W-1:0] n_clamped;
    logic [mf3_pkg::COL_W-1:0] r_col;
    logic [mf3_pkg::ROW_W-1:0] r_row;
    logic                      accept;
    logic                      last_col;
    logic                      last_row;
    logic [mf3_pkg::LVL_W-1:0] n_level;

    logic                      r_s1_valid;
    logic                      r_s1_emit;
    logic                      r_s1_line_end;
    logic                      r_s1_frame_end;
    logic [mf3_pkg::COL_W-1:0] r_s1_col;
    mf3_pkg::t_pix             r_s1_pix;

    logic [2*mf3_pkg::PIX_W-1:0] ram_rdata;
    logic [2*mf3_pkg::PIX_W-1:0] ram_wdata;
    mf3_pkg::t_pix               top_pix;
    mf3_pkg::t_pix               mid_pix;
    mf3_pkg::t_win               r_win;
    mf3_pkg::t_win               n_win;

    // Clamp a written dimension into the supported range.
    always_comb begin
        if (i_cfg_wdata < mf3_pkg::DIM_W'(mf3_pkg::MIN_DIM)) begin
            n_clamped = mf3_pkg::DIM_W'(mf3_pkg::MIN_DIM);
        end else if (i_cfg_wdata > mf3_pkg::DIM_W'(mf3_pkg::MAX_WIDTH)) begin
            n_clamped = mf3_pkg::DIM_W'(mf3_pkg::MAX_WIDTH);
        end else begin
            n_clamped = i_cfg_wdata;
        end
    end

    // Geometry registers; writes to unused indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= mf3_pkg::DIM_W'(640);
            r_height <= mf3_pkg::DIM_W'(480);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                mf3_pkg::REG_IMAGE_WIDTH:  r_width <= n_clamped;
                mf3_pkg::REG_IMAGE_HEIGHT: begin
                    if (n_clamped > mf3_pkg::DIM_W'(mf3_pkg::MAX_HEIGHT)) begin
                        r_height <= mf3_pkg::DIM_W'(mf3_pkg::MAX_HEIGHT);
                    end else begin
                        r_height <= n_clamped;
                    end
                end
                default: ;
            endcase
        end
    end

    // Hold off the source when the queue could not absorb the item in flight.
    assign n_level = i_q_level + mf3_pkg::LVL_W'(r_s1_valid);
    assign o_stall = (n_level >= mf3_pkg::LVL_W'(mf3_pkg::QDEPTH));
    assign accept  = i_valid && !o_stall;

    assign last_col = {1'b0, r_col} >= (r_width - mf3_pkg::DIM_W'(1));
    assign last_row = {1'b0, r_row} >= (r_height - mf3_pkg::DIM_W'(1));

    // Raster position of the next incoming pixel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + mf3_pkg::ROW_W'(1);
            end else begin
                r_col <= r_col + mf3_pkg::COL_W'(1);
            end
        end
    end

    // Stage 1 holds the accepted pixel while the line store read data is registered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix       <= i_pixel;
            r_s1_col       <= r_col;
            r_s1_emit      <= (r_row >= mf3_pkg::ROW_W'(2)) && (r_col >= mf3_pkg::COL_W'(2));
            r_s1_line_end  <= last_col;
            r_s1_frame_end <= last_col && last_row;
        end
    end

    // Both line stores share one RAM: upper line in the high byte.
    assign top_pix   = ram_rdata[2*mf3_pkg::PIX_W-1:mf3_pkg::PIX_W];
    assign mid_pix   = ram_rdata[mf3_pkg::PIX_W-1:0];
    assign ram_wdata = {mid_pix, r_s1_pix};

    mf3_ram #(
        .WIDTH (2 * mf3_pkg::PIX_W),
        .DEPTH (mf3_pkg::MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    // Slide the window one column and load the new right-hand column.
    always_comb begin
        n_win    = r_win;
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = top_pix;
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[5] = mid_pix;
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[8] = r_s1_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (r_s1_valid) begin
            r_win <= n_win;
        end
    end

    // Only windows around interior pixels go on to the back end.
    assign o_push           = r_s1_valid && r_s1_emit;
    assign o_item.win       = n_win;
    assign o_item.line_end  = r_s1_line_end;
    assign o_item.frame_end = r_s1_frame_end;

    `MF3_ASSERT_NEXT(a_s1_one_cycle, i_clk, i_rst_n, r_s1_valid && !accept, !r_s1_valid, "stage 1 item did not leave after one cycle")

endmodule

// ===== sv/mf3_fifo.sv =====
// Short queue of windows between the front end and the sorting back end.
// Depends on mf3_pkg and the assertion macro header.
`include "median_filter_3x3_defines.svh"

module mf3_fifo (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  mf3_pkg::t_item            i_item,
    input  logic                      i_pop,
    output mf3_pkg::t_item            o_item,
    output logic                      o_nonempty,
    output logic [mf3_pkg::LVL_W-1:0] o_level
);

    mf3_pkg::t_item            r_mem [mf3_pkg::QDEPTH];
    logic [mf3_pkg::QA_W-1:0]  r_wr_ptr;
    logic [mf3_pkg::QA_W-1:0]  r_rd_ptr;
    logic [mf3_pkg::LVL_W-1:0] r_count;

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + mf3_pkg::QA_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + mf3_pkg::QA_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + mf3_pkg::LVL_W'(1);
                2'b01:   r_count <= r_count - mf3_pkg::LVL_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_item     = r_mem[r_rd_ptr];
    assign o_nonempty = (r_count != '0);
    assign o_level    = r_count;

    `MF3_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, r_count == mf3_pkg::LVL_W'(mf3_pkg::QDEPTH), !i_push, "item pushed into a full queue")
    `MF3_ASSERT_NOW(a_no_underflow, i_clk, i_rst_n, i_pop, r_count != '0, "item popped from an empty queue")

endmodule

// ===== sv/mf3_back.sv =====
// Back end: three-stage median-of-nine sorting network with output register.
// Depends on mf3_pkg and the assertion macro header.
`include "median_filter_3x3_defines.svh"

module mf3_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mf3_pkg::t_item i_item,
    input  logic           i_nonempty,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output mf3_pkg::t_pix  o_median,
    output logic           o_line_end,
    output logic           o_frame_end
);

    // Compare-exchange: lower value to slot a, higher to slot b.
    function automatic mf3_pkg::t_win cx(input mf3_pkg::t_win w,
                                         input logic [3:0] a,
                                         input logic [3:0] b);
        mf3_pkg::t_win res;
        res = w;
        if (w[a] > w[b]) begin
            res[a] = w[b];
            res[b] = w[a];
        end
        return res;
    endfunction

    // Layers one to three: sort each row of three.
    function automatic mf3_pkg::t_win net_a(input mf3_pkg::t_win w);
        mf3_pkg::t_win v;
        v = w;
        v = cx(v, 4'd1, 4'd2); v = cx(v, 4'd4, 4'd5); v = cx(v, 4'd7, 4'd8);
        v = cx(v, 4'd0, 4'd1); v = cx(v, 4'd3, 4'd4); v = cx(v, 4'd6, 4'd7);
        v = cx(v, 4'd1, 4'd2); v = cx(v, 4'd4, 4'd5); v = cx(v, 4'd7, 4'd8);
        return v;
    endfunction

    // Layers four to six: column maxima, medians and minima.
    function automatic mf3_pkg::t_win net_b(input mf3_pkg::t_win w);
        mf3_pkg::t_win v;
        v = w;
        v = cx(v, 4'd0, 4'd3); v = cx(v, 4'd5, 4'd8); v = cx(v, 4'd4, 4'd7);
        v = cx(v, 4'd3, 4'd6); v = cx(v, 4'd1, 4'd4); v = cx(v, 4'd2, 4'd5);
        v = cx(v, 4'd4, 4'd7);
        return v;
    endfunction

    // Layers seven to nine: settle the center value.
    function automatic mf3_pkg::t_win net_c(input mf3_pkg::t_win w);
        mf3_pkg::t_win v;
        v = w;
        v = cx(v, 4'd4, 4'd2);
        v = cx(v, 4'd6, 4'd4);
        v = cx(v, 4'd4, 4'd2);
        return v;
    endfunction

    logic           r_a_valid;
    logic           r_b_valid;
    logic           r_c_valid;
    mf3_pkg::t_item r_a;
    mf3_pkg::t_item r_b;
    mf3_pkg::t_win  c_win;
    mf3_pkg::t_pix  r_median;
    logic           r_line_end;
    logic           r_frame_end;
    logic           rdy_a;
    logic           rdy_b;
    logic           rdy_c;

    // Each stage moves on when the stage after it has room.
    assign rdy_c = !r_c_valid || !i_stall;
    assign rdy_b = !r_b_valid || rdy_c;
    assign rdy_a = !r_a_valid || rdy_b;
    assign o_pop = i_nonempty && rdy_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_a_valid <= i_nonempty;
            end
            if (rdy_b) begin
                r_b_valid <= r_a_valid;
            end
            if (rdy_c) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    // Network stage registers.
    always_ff @(posedge i_clk) begin
        if (rdy_a) begin
            r_a.win       <= net_a(i_item.win);
            r_a.line_end  <= i_item.line_end;
            r_a.frame_end <= i_item.frame_end;
        end
        if (rdy_b) begin
            r_b.win       <= net_b(r_a.win);
            r_b.line_end  <= r_a.line_end;
            r_b.frame_end <= r_a.frame_end;
        end
    end

    // Output register holds the median until the receiver takes it.
    assign c_win = net_c(r_b.win);

    always_ff @(posedge i_clk) begin
        if (rdy_c) begin
            r_median    <= c_win[4];
            r_line_end  <= r_b.line_end;
            r_frame_end <= r_b.frame_end;
        end
    end

    assign o_valid     = r_c_valid;
    assign o_median    = r_median;
    assign o_line_end  = r_line_end;
    assign o_frame_end = r_frame_end;

    `MF3_ASSERT_NEXT(a_b_held, i_clk, i_rst_n, r_b_valid && r_c_valid && i_stall, r_b_valid, "stage B item lost under output stall")

endmodule

// ===== sv/median_filter_3x3.sv =====
// Top level of the streaming 3x3 median filter.
// Depends on mf3_pkg, mf3_front, mf3_fifo and mf3_back.
//
// Usage:
// Pixels enter in raster order on i_pixel with i_valid; an item is taken at
// a clock edge where i_valid is high and o_stall is low. For each pixel whose
// whole 3x3 neighborhood lies inside the image, one result leaves on
// o_median with o_valid, taken when i_stall is low. o_line_end marks the last
// result of a line and o_frame_end the last result of a frame; border pixels
// give no result. Image width and height are written on the configuration
// port (index 0 and 1); the user must do so only while the block is idle,
// which the block itself does not enforce. Values are clamped to 3..1024.
// Throughput is one pixel per cycle while o_stall is low, set by the registered
// line store read in the front end and the three-stage sorting network in the
// back end. When the receiver stalls, results back up through the sorting
// stages and a four-entry queue, and o_stall rises once the queue cannot take
// another item. Synchronous reset clears the counters, window and queue and
// restores a 640x480 geometry; the line stores need no clearing pass.
module median_filter_3x3 (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [mf3_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [mf3_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [7:0]                     i_pixel,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [7:0]                     o_median,
    output logic                           o_line_end,
    output logic                           o_frame_end
);

    logic                      q_push;
    logic                      q_pop;
    logic                      q_nonempty;
    logic [mf3_pkg::LVL_W-1:0] q_level;
    mf3_pkg::t_item            q_in;
    mf3_pkg::t_item            q_out;

    // Front end: counters, line stores and window.
    mf3_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .i_pixel     (i_pixel),
        .o_stall     (o_stall),
        .i_q_level   (q_level),
        .o_push      (q_push),
        .o_item      (q_in)
    );

    // Queue between the two halves.
    mf3_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_item     (q_in),
        .i_pop      (q_pop),
        .o_item     (q_out),
        .o_nonempty (q_nonempty),
        .o_level    (q_level)
    );

    // Back end: sorting network and output register.
    mf3_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (q_out),
        .i_nonempty  (q_nonempty),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_median    (o_median),
        .o_line_end  (o_line_end),
        .o_frame_end (o_frame_end)
    );

endmodule

// ===== tb/sv/median_checker.sv =====
`timescale 1ns / 100ps
// Passive checker for the 3x3 median filter: predicts each result and compares.
// Depends on mf3_pkg; watches the pixel, result and configuration ports.
module median_checker
    import mf3_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_pix_valid,
    input  logic                  i_pix_stall,
    input  logic [PIX_W-1:0]      i_pixel,
    input  logic                  i_res_valid,
    input  logic                  i_res_stall,
    input  logic [PIX_W-1:0]      i_median,
    input  logic                  i_line_end,
    input  logic                  i_frame_end,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_frame_left
);

    typedef struct packed {
        t_pix median;
        logic line_end;
        logic frame_end;
    } t_filtered;

    // Shadow copy of the filter state.
    t_pix        upper_line [MAX_WIDTH];
    t_pix        middle_line [MAX_WIDTH];
    t_pix        window [WIN_N];
    int unsigned col_pos;
    int unsigned row_pos;
    int unsigned width_eff;
    int unsigned height_eff;

    t_filtered   filtered_q [$];
    int          fail_count = 0;

    // Written geometry is held to the range the line stores support.
    function automatic int unsigned clamp_dim(input logic [CFG_DATA_W-1:0] raw,
                                              input int unsigned max_dim);
        if (raw < MIN_DIM) return MIN_DIM;
        if (raw > max_dim) return max_dim;
        return 32'(raw);
    endfunction

    // Median of nine by an insertion sort of a local copy.
    function automatic t_pix median_of_window(input t_pix w [WIN_N]);
        t_pix sorted [WIN_N];
        t_pix key;
        int   j;
        sorted = w;
        for (int i = 1; i < WIN_N; i++) begin
            key = sorted[i];
            j = i - 1;
            while (j >= 0 && sorted[j] > key) begin
                sorted[j + 1] = sorted[j];
                j--;
            end
            sorted[j + 1] = key;
        end
        return sorted[WIN_N / 2];
    endfunction

    assign o_fail_count = fail_count;
    assign o_pending    = filtered_q.size();

    // Pixels still to come before the stream is back at the top left corner.
    assign o_frame_left = ((col_pos >= width_eff - 1) ? 1 : width_eff - col_pos)
                        + ((row_pos >= height_eff - 1) ? 0 : height_eff - 1 - row_pos)
                          * width_eff;

    always @(posedge i_clk) begin : monitor
        t_filtered   want;
        t_filtered   next_res;
        int unsigned idx;
        t_pix        top_px;
        t_pix        mid_px;
        logic        last_col;
        logic        last_row;
        if (!i_rst_n) begin
            width_eff  = 640;
            height_eff = 480;
            col_pos    = 0;
            row_pos    = 0;
            foreach (upper_line[i]) upper_line[i] = '0;
            foreach (middle_line[i]) middle_line[i] = '0;
            foreach (window[i]) window[i] = '0;
            filtered_q.delete();
        end else begin
            // Configuration writes take effect for the next pixel.
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    REG_IMAGE_WIDTH:  width_eff  = clamp_dim(i_cfg_wdata, MAX_WIDTH);
                    REG_IMAGE_HEIGHT: height_eff = clamp_dim(i_cfg_wdata, MAX_HEIGHT);
                    default: ;
                endcase
            end

            // Compare an accepted result with the oldest prediction.
            if (i_res_valid && !i_res_stall) begin
                if (filtered_q.size() == 0) begin
                    $display("%0t: unexpected result, median %0d line_end %0b frame_end %0b",
                             $time, i_median, i_line_end, i_frame_end);
                    fail_count++;
                end else begin
                    want = filtered_q.pop_front();
                    if (i_median !== want.median) begin
                        $display("%0t: median mismatch, expected %0d, actual %0d",
                                 $time, want.median, i_median);
                        fail_count++;
                    end
                    if (i_line_end !== want.line_end) begin
                        $display("%0t: line_end mismatch, expected %0b, actual %0b",
                                 $time, want.line_end, i_line_end);
                        fail_count++;
                    end
                    if (i_frame_end !== want.frame_end) begin
                        $display("%0t: frame_end mismatch, expected %0b, actual %0b",
                                 $time, want.frame_end, i_frame_end);
                        fail_count++;
                    end
                end
            end

            // Advance the shadow window and line stores on each accepted item.
            if (i_pix_valid && !i_pix_stall) begin
                idx      = (col_pos < MAX_WIDTH) ? col_pos : MAX_WIDTH - 1;
                top_px   = upper_line[idx];
                mid_px   = middle_line[idx];
                last_col = (col_pos >= width_eff - 1);
                last_row = (row_pos >= height_eff - 1);
                for (int r = 0; r < 3; r++) begin
                    window[3 * r]     = window[3 * r + 1];
                    window[3 * r + 1] = window[3 * r + 2];
                end
                window[2] = top_px;
                window[5] = mid_px;
                window[8] = i_pixel;
                upper_line[idx]  = mid_px;
                middle_line[idx] = i_pixel;

                // Only centers with a full neighborhood give a result.
                if (row_pos >= 2 && col_pos >= 2) begin
                    next_res.median    = median_of_window(window);
                    next_res.line_end  = last_col;
                    next_res.frame_end = last_col && last_row;
                    filtered_q.push_back(next_res);
                end

                if (last_col) begin
                    col_pos = 0;
                    row_pos = last_row ? 0 : row_pos + 1;
                end else begin
                    col_pos = col_pos + 1;
                end
            end
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Top of the median filter testbench: clock, reset, pixel stimulus, stalls, verdict.
// Depends on mf3_pkg, median_filter_3x3 and median_checker.
module tb;
    import mf3_pkg::*;

    localparam int RANDOM_ITEMS  = 650;
    localparam int DRAIN_CYCLES  = 16;
    localparam int RUN_LIMIT_NS  = 4_000_000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} t_stall_mode;
    typedef enum {PIX_UNIFORM, PIX_EXTREME, PIX_NARROW, PIX_OUTLIER} t_pix_style;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_valid     = 1'b0;
    logic [7:0]            i_pixel     = '0;
    logic                  i_stall     = 1'b0;
    logic                  o_stall;
    logic                  o_valid;
    logic [7:0]            o_median;
    logic                  o_line_end;
    logic                  o_frame_end;

    int fail_count;
    int pending;
    int frame_left;

    // Stimulus bookkeeping: raw values last written, items accepted so far.
    logic [CFG_DATA_W-1:0] width_raw;
    logic [CFG_DATA_W-1:0] height_raw;
    int                    pixels_sent = 0;

    median_filter_3x3 u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_pixel     (i_pixel),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_median    (o_median),
        .o_line_end  (o_line_end),
        .o_frame_end (o_frame_end)
    );

    median_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_pix_valid  (i_valid),
        .i_pix_stall  (o_stall),
        .i_pixel      (i_pixel),
        .i_res_valid  (o_valid),
        .i_res_stall  (i_stall),
        .i_median     (o_median),
        .i_line_end   (o_line_end),
        .i_frame_end  (o_frame_end),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_frame_left (frame_left)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Receiver back-pressure: modes of random length, from none to long runs.
    t_stall_mode stall_mode = STALL_NONE;
    int          mode_left  = 0;
    int          run_left   = 0;
    logic        run_stall  = 1'b0;

    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            mode_left  = $urandom_range(16, 160);
        end
        mode_left--;
        case (stall_mode)
            STALL_NONE:  i_stall <= 1'b0;
            STALL_LIGHT: i_stall <= ($urandom_range(0, 7) == 0);
            STALL_HEAVY: i_stall <= 1'($urandom_range(0, 1));
            default: begin
                if (run_left == 0) begin
                    run_stall = ~run_stall;
                    run_left  = run_stall ? $urandom_range(5, 30) : $urandom_range(1, 4);
                end
                run_left--;
                i_stall <= run_stall;
            end
        endcase
    end

    // One register write; the enable drops in its own cycle.
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_IMAGE_WIDTH) width_raw = data;
        if (idx == REG_IMAGE_HEIGHT) height_raw = data;
    endtask

    // Present one item and hold it until the filter takes it.
    task automatic send_pixel(input t_pix px);
        i_valid <= 1'b1;
        i_pixel <= px;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pixels_sent++;
    endtask

    // A burst of items in one value style, then a random gap.
    task automatic send_burst(input int count);
        t_pix_style style;
        t_pix       base;
        int         gap;
        style = t_pix_style'($urandom_range(0, 3));
        base  = t_pix'($urandom_range(0, 255));
        for (int i = 0; i < count; i++) begin
            case (style)
                PIX_UNIFORM: send_pixel(t_pix'($urandom_range(0, 255)));
                PIX_EXTREME: send_pixel($urandom_range(0, 1) ? 8'hFF : 8'h00);
                PIX_NARROW:  send_pixel(base ^ t_pix'($urandom_range(0, 7)));
                default:     send_pixel(($urandom_range(0, 5) == 0)
                                        ? t_pix'($urandom_range(0, 255)) : base);
            endcase
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop sending and wait until every predicted result has left the filter.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Geometry for a new frame: mostly small, sometimes clamped or very large.
    function automatic logic [CFG_DATA_W-1:0] pick_dim(input int common_hi);
        case ($urandom_range(0, 15))
            0:       return CFG_DATA_W'($urandom_range(0, 2));
            1:       return $urandom_range(0, 1) ? 11'd1024 : 11'd2047;
            2:       return CFG_DATA_W'($urandom_range(41, 1023));
            3:       return CFG_DATA_W'($urandom_range(common_hi + 1, 40));
            default: return CFG_DATA_W'($urandom_range(3, common_hi));
        endcase
    endfunction

    initial begin
        #(RUN_LIMIT_NS);
        $display("status: fail");
        $finish;
    end

    initial begin
        int left;
        int chunk;
        int target;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: clamp of small values, spare register indexes, one 3x3 frame.
        write_cfg(REG_IMAGE_WIDTH, 11'd0);
        write_cfg(REG_IMAGE_HEIGHT, 11'd2);
        write_cfg(REG_SPARE_A, 11'h7FF);
        write_cfg(REG_SPARE_B, 11'h2AA);
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'hFF);
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'hFF);
        send_pixel(8'h00);
        drain();

        // Directed: oversize geometry clamps to the maximum, then shrinks mid-line
        // below the column counter, so the line ends at the next item.
        write_cfg(REG_IMAGE_WIDTH, 11'd2047);
        write_cfg(REG_IMAGE_HEIGHT, 11'd1024);
        for (int i = 0; i < 6; i++) send_pixel(t_pix'($urandom_range(0, 255)));
        drain();
        write_cfg(REG_IMAGE_WIDTH, 11'd1);
        for (int i = 0; i < 7; i++) send_pixel(t_pix'($urandom_range(0, 255)));
        drain();

        // Directed: height drops below the row counter, so this line ends the frame.
        write_cfg(REG_IMAGE_HEIGHT, 11'd2);
        for (int i = 0; i < 3; i++) send_pixel(t_pix'($urandom_range(0, 255)));
        drain();

        // Random stream with geometry changes at frame starts and mid-frame.
        target = pixels_sent + RANDOM_ITEMS;
        while (pixels_sent < target) begin
            send_burst(($urandom_range(0, 9) == 0) ? $urandom_range(17, 48)
                                                   : $urandom_range(1, 16));
            if (((width_raw > 40 || height_raw > 24) && $urandom_range(0, 2) != 0)
                    || $urandom_range(0, 5) == 0) begin
                drain();
                if (width_raw > 40 || height_raw > 24) begin
                    // Large geometry only lasts a little while; shrinking is safe anywhere.
                    if (width_raw > 40)
                        write_cfg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(0, 12)));
                    if (height_raw > 24)
                        write_cfg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(0, 8)));
                end else if ($urandom_range(0, 1)) begin
                    // Mid-frame: width may only shrink, height may move either way.
                    if ($urandom_range(0, 1))
                        write_cfg(REG_IMAGE_WIDTH,
                                  CFG_DATA_W'($urandom_range(0, width_raw)));
                    if ($urandom_range(0, 1))
                        write_cfg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(0, 9)));
                    if ($urandom_range(0, 3) == 0)
                        write_cfg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                                  CFG_DATA_W'($urandom_range(0, 2047)));
                end else begin
                    // Finish the frame, then pick any geometry for the next one.
                    left = frame_left;
                    while (left > 0) begin
                        chunk = $urandom_range(1, 16);
                        if (chunk > left) chunk = left;
                        send_burst(chunk);
                        left -= chunk;
                    end
                    drain();
                    write_cfg(REG_IMAGE_WIDTH, pick_dim(12));
                    write_cfg(REG_IMAGE_HEIGHT, pick_dim(8));
                end
            end
        end

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== median_filter_3x3.f =====
+incdir+sv
sv/mf3_pkg.sv
sv/mf3_ram.sv
sv/mf3_front.sv
sv/mf3_fifo.sv
sv/mf3_back.sv
sv/median_filter_3x3.sv
tb/sv/median_checker.sv
tb/sv/tb.sv
